/* hw/rtl/prime_modular_arith_unit_defines.svh */
// Assertion macros for the files that check their own logic.
`ifndef PRIME_MODULAR_ARITH_UNIT_DEFINES_SVH
`define PRIME_MODULAR_ARITH_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pma_pkg.sv */
package pma_pkg;
	localparam int DW = 30;
	localparam int CW = 32;
	localparam int EW = 63;
	localparam int FW = 3;

	localparam logic [FW-1:0] FN_ADD = 3'd0;
	localparam logic [FW-1:0] FN_SUB = 3'd1;
	localparam logic [FW-1:0] FN_MUL = 3'd2;
	localparam logic [FW-1:0] FN_DIV = 3'd3;
	localparam logic [FW-1:0] FN_POW = 3'd4;
	localparam logic [FW-1:0] FN_INV = 3'd5;

	typedef logic [DW-1:0] resid_t;
	typedef logic signed [CW-1:0] coef_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;
endpackage

/* hw/rtl/pma_mulmod.sv */
module pma_mulmod #(
	parameter int unsigned MODULUS = 998244353
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pma_pkg::resid_t     y,
	input  pma_pkg::resid_t     x,
	output pma_pkg::unit_stat_t stat,
	output pma_pkg::resid_t     prod
);
	import pma_pkg::*;

	localparam int CNTW = $clog2(DW);
	localparam logic [DW+1:0] M1 = (DW+2)'(MODULUS);
	localparam logic [DW+1:0] M2 = (DW+2)'(2 * MODULUS);

	resid_t y_q, x_q, acc_q;
	logic [CNTW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DW+1:0] t, nxt;

	always_comb begin
		t = {1'b0, acc_q, 1'b0} + (y_q[DW-1] ? {2'b00, x_q} : '0);
		if (t >= M2) begin
			nxt = t - M2;
		end else if (t >= M1) begin
			nxt = t - M1;
		end else begin
			nxt = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q   <= y;
			x_q   <= x;
			acc_q <= '0;
		end else if (busy_q) begin
			y_q   <= y_q << 1;
			acc_q <= nxt[DW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;
endmodule

/* hw/rtl/pma_divstep.sv */
module pma_divstep (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pma_pkg::resid_t     num,
	input  pma_pkg::resid_t     den,
	input  pma_pkg::coef_t      ca,
	input  pma_pkg::coef_t      cb,
	output pma_pkg::unit_stat_t stat,
	output pma_pkg::resid_t     rem,
	output pma_pkg::coef_t      tc
);
	import pma_pkg::*;

	localparam int CNTW = $clog2(DW);

	resid_t n_q, d_q, r_q;
	coef_t ca_q, cb_q, t_q;
	logic [CNTW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DW:0] rs, rn;
	logic ge;

	always_comb begin
		rs = {r_q, n_q[DW-1]};
		ge = rs >= {1'b0, d_q};
		rn = ge ? rs - {1'b0, d_q} : rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q  <= num;
			d_q  <= den;
			r_q  <= '0;
			ca_q <= ca;
			cb_q <= cb;
			t_q  <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			r_q <= rn[DW-1:0];
			t_q <= (t_q <<< 1) + (ge ? cb_q : '0);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = r_q;
	assign tc        = ca_q - t_q;
endmodule

/* hw/rtl/prime_modular_arith_unit.sv */
// Modular arithmetic unit: one item at a time, one result per item, modulo MODULUS. Both
// operands are first reduced on a bit-serial shift-add modular multiplier, which also does
// every product; a restoring divider that runs one quotient bit a cycle does each extended
// Euclid step. Add and sub follow the reduction directly, mul takes one product, pow one
// square per exponent bit up to its top one and one product per one bit, inverse Euclid
// steps until the remainder is zero, and div an inverse plus one product.
// The input is not ready while an item is in work.
module prime_modular_arith_unit #(
	parameter int unsigned MODULUS = 998244353
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pma_pkg::FW-1:0]      func,
	input  logic [pma_pkg::DW-1:0]      operand_a,
	input  logic [pma_pkg::DW-1:0]      operand_b,
	input  logic [pma_pkg::EW-1:0]      exponent,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pma_pkg::DW-1:0]      result
);
	import pma_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RED_A = 4'd1;
	localparam logic [3:0] S_RED_B = 4'd2;
	localparam logic [3:0] S_DISP  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_POW_M = 4'd5;
	localparam logic [3:0] S_POW_S = 4'd6;
	localparam logic [3:0] S_EUC   = 4'd7;
	localparam logic [3:0] S_FIX   = 4'd8;
	localparam logic [3:0] S_DIV_M = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	localparam logic [DW:0] MX = (DW+1)'(MODULUS);
	localparam coef_t MC = CW'(MODULUS);

	logic [3:0] state_q;
	logic launched_q, out_valid_q;
	logic [FW-1:0] func_q;
	resid_t a_q, b_q, acc_q, sq_q, ra_q, rb_q, res_q, result_q;
	coef_t ca_q, cb_q;
	logic [EW-1:0] e_q;

	logic mm_start, dv_start, mm_use;
	resid_t mm_y, mm_x, mm_prod, dv_rem;
	coef_t dv_tc, fixed;
	unit_stat_t mm_stat, dv_stat;
	logic [DW:0] sum, diff;
	logic [EW-1:0] e_sh;
	logic load_out;

	always_comb begin
		mm_use = 1'b1;
		mm_y   = a_q;
		mm_x   = b_q;
		case (state_q)
			S_RED_A: begin
				mm_y = a_q;
				mm_x = DW'(1);
			end
			S_RED_B: begin
				mm_y = b_q;
				mm_x = DW'(1);
			end
			S_MUL, S_DIV_M: begin
				mm_y = a_q;
				mm_x = b_q;
			end
			S_POW_M: begin
				mm_y   = acc_q;
				mm_x   = sq_q;
				mm_use = e_q[0];
			end
			S_POW_S: begin
				mm_y = sq_q;
				mm_x = sq_q;
			end
			default: begin
				mm_use = 1'b0;
			end
		endcase
		mm_start = mm_use && !launched_q;
		dv_start = (state_q == S_EUC) && (rb_q != '0) && !launched_q;
	end

	pma_mulmod #(.MODULUS(MODULUS)) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.y     (mm_y),
		.x     (mm_x),
		.stat  (mm_stat),
		.prod  (mm_prod)
	);

	pma_divstep u_divstep (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dv_start),
		.num   (ra_q),
		.den   (rb_q),
		.ca    (ca_q),
		.cb    (cb_q),
		.stat  (dv_stat),
		.rem   (dv_rem),
		.tc    (dv_tc)
	);

	always_comb begin
		sum  = {1'b0, a_q} + {1'b0, b_q};
		diff = {1'b0, a_q} - {1'b0, b_q};
		if (sum >= MX) begin
			sum = sum - MX;
		end
		if (a_q < b_q) begin
			diff = diff + MX;
		end
		if (ca_q < 0) begin
			fixed = ca_q + MC;
		end else if (ca_q >= MC) begin
			fixed = ca_q - MC;
		end else begin
			fixed = ca_q;
		end
		e_sh     = e_q >> 1;
		load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mm_start || dv_start) begin
				launched_q <= 1'b1;
			end else if (mm_stat.done || dv_stat.done) begin
				launched_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RED_A;
					end
				end
				S_RED_A: begin
					if (mm_stat.done) begin
						state_q <= S_RED_B;
					end
				end
				S_RED_B: begin
					if (mm_stat.done) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (func_q)
						FN_MUL: state_q <= S_MUL;
						FN_DIV, FN_INV: state_q <= S_EUC;
						FN_POW: state_q <= (e_q == '0) ? S_DONE : S_POW_M;
						default: state_q <= S_DONE;
					endcase
				end
				S_MUL, S_DIV_M: begin
					if (mm_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_POW_M: begin
					if (!e_q[0] || mm_stat.done) begin
						state_q <= S_POW_S;
					end
				end
				S_POW_S: begin
					if (mm_stat.done) begin
						state_q <= (e_sh == '0) ? S_DONE : S_POW_M;
					end
				end
				S_EUC: begin
					if (rb_q == '0) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					state_q <= (func_q == FN_DIV) ? S_DIV_M : S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				func_q <= func;
				a_q    <= operand_a;
				b_q    <= operand_b;
				e_q    <= exponent;
			end
			S_RED_A: begin
				if (mm_stat.done) begin
					a_q <= mm_prod;
				end
			end
			S_RED_B: begin
				if (mm_stat.done) begin
					b_q <= mm_prod;
				end
			end
			S_DISP: begin
				acc_q <= DW'(1);
				sq_q  <= a_q;
				ca_q  <= CW'(1);
				cb_q  <= '0;
				rb_q  <= DW'(MODULUS);
				ra_q  <= (func_q == FN_DIV) ? b_q : a_q;
				case (func_q)
					FN_ADD: res_q <= sum[DW-1:0];
					FN_SUB: res_q <= diff[DW-1:0];
					FN_POW: res_q <= DW'(1);
					default: res_q <= '0;
				endcase
			end
			S_MUL, S_DIV_M: begin
				if (mm_stat.done) begin
					res_q <= mm_prod;
				end
			end
			S_POW_M: begin
				if (mm_stat.done) begin
					acc_q <= mm_prod;
				end
			end
			S_POW_S: begin
				res_q <= acc_q;
				if (mm_stat.done) begin
					sq_q <= mm_prod;
					e_q  <= e_sh;
				end
			end
			S_EUC: begin
				if (dv_stat.done) begin
					ra_q <= rb_q;
					rb_q <= dv_rem;
					ca_q <= cb_q;
					cb_q <= dv_tc;
				end
			end
			S_FIX: begin
				res_q <= fixed[DW-1:0];
				b_q   <= fixed[DW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign result    = result_q;

`include "prime_modular_arith_unit_defines.svh"

	`PMA_ASSERT_SAME(a_result_range, out_valid, 32'(result) < MODULUS, "result not reduced")
	`PMA_ASSERT_SAME(a_unit_free, mm_start || dv_start, !mm_stat.busy && !dv_stat.busy, "unit busy")
	`PMA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready after accept")
	`PMA_ASSERT_SAME(a_euclid_rem, dv_stat.done, dv_rem < rb_q, "remainder too large")
endmodule

/* tb/sv/prime_modular_arith_unit_tb.sv */
module prime_modular_arith_unit_tb;
	import pma_pkg::*;

	localparam longint unsigned PRIME = 998244353;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [FW-1:0] func;
	logic [DW-1:0] operand_a;
	logic [DW-1:0] operand_b;
	logic [EW-1:0] exponent;
	logic out_valid;
	logic out_ready;
	logic [DW-1:0] result;

	resid_t expected_residues[$];
	int error_count = 0;
	int result_count = 0;
	int item_count = 0;
	int op_count[8];
	int idle_cycles = 0;
	bit hold_output = 0;
	bit long_stalls = 1;

	prime_modular_arith_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result(result)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y);
		return (x * y) % PRIME;
	endfunction

	function automatic longint unsigned powmod(longint unsigned base, logic [EW-1:0] e);
		longint unsigned acc;
		longint unsigned sq;
		acc = 1;
		sq = base;
		for (int i = 0; i < EW; i++) begin
			if (e[i]) begin
				acc = mulmod(acc, sq);
			end
			sq = mulmod(sq, sq);
		end
		return acc;
	endfunction

	function automatic longint unsigned invmod(longint unsigned x);
		longint ra;
		longint rb;
		longint ca;
		longint cb;
		longint q;
		longint t;
		ra = x;
		rb = PRIME;
		ca = 1;
		cb = 0;
		while (rb != 0) begin
			q = ra / rb;
			t = ra - q * rb;
			ra = rb;
			rb = t;
			t = ca - q * cb;
			ca = cb;
			cb = t;
		end
		ca = ca % longint'(PRIME);
		if (ca < 0) begin
			ca += PRIME;
		end
		return ca;
	endfunction

	function automatic resid_t predict_residue(logic [FW-1:0] f, logic [DW-1:0] ra,
			logic [DW-1:0] rb, logic [EW-1:0] e);
		longint unsigned a;
		longint unsigned b;
		longint unsigned r;
		a = ra % PRIME;
		b = rb % PRIME;
		case (f)
			FN_ADD: begin
				r = a + b;
				if (r >= PRIME) begin
					r -= PRIME;
				end
			end
			FN_SUB: r = (a >= b) ? a - b : a + PRIME - b;
			FN_MUL: r = mulmod(a, b);
			FN_DIV: r = mulmod(a, invmod(b));
			FN_POW: r = powmod(a, e);
			FN_INV: r = invmod(a);
			default: r = 0;
		endcase
		return resid_t'(r);
	endfunction

	function automatic int gap_length();
		if (long_stalls && $urandom_range(0, 19) == 0) begin
			return $urandom_range(20, 80);
		end
		if ($urandom_range(0, 2) == 0) begin
			return 0;
		end
		return $urandom_range(0, 3);
	endfunction

	task automatic send_request(logic [FW-1:0] f, logic [DW-1:0] a, logic [DW-1:0] b,
			logic [EW-1:0] e);
		int gap;
		gap = gap_length();
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		operand_a <= a;
		operand_b <= b;
		exponent <= e;
		do @(posedge clk); while (!in_ready);
		expected_residues = {expected_residues, predict_residue(f, a, b, e)};
		op_count[f]++;
		item_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (expected_residues.size() != 0) @(posedge clk);
	endtask

	function automatic logic [DW-1:0] rand_residue();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return DW'(PRIME - 1);
			2: return DW'($urandom_range(0, 15));
			3: return DW'($urandom_range(DW'(PRIME), (1 << DW) - 1));
			default: return DW'($urandom_range(0, PRIME - 1));
		endcase
	endfunction

	function automatic logic [EW-1:0] rand_exponent();
		logic [EW-1:0] e;
		e = EW'({$urandom, $urandom});
		case ($urandom_range(0, 5))
			0: return EW'($urandom_range(0, 3));
			1: return e;
			2: return ~EW'(0);
			default: return e >> $urandom_range(0, EW - 1);
		endcase
	endfunction

	task automatic test_directed();
		send_request(FN_ADD, 0, 0, 0);
		send_request(FN_ADD, DW'(PRIME - 1), DW'(PRIME - 1), 0);
		send_request(FN_ADD, ~DW'(0), ~DW'(0), ~EW'(0));
		send_request(FN_SUB, 0, DW'(PRIME - 1), 0);
		send_request(FN_SUB, DW'(PRIME), 1, 0);
		send_request(FN_MUL, DW'(PRIME - 1), DW'(PRIME - 1), 0);
		send_request(FN_MUL, ~DW'(0), 12345, 0);
		send_request(FN_DIV, 7, 0, 0);
		send_request(FN_DIV, 1, DW'(PRIME - 1), 0);
		send_request(FN_DIV, 5, DW'(PRIME), 0);
		send_request(FN_POW, 0, 0, 0);
		send_request(FN_POW, 3, 0, 0);
		send_request(FN_POW, 0, 0, 5);
		send_request(FN_POW, DW'(PRIME - 1), 0, ~EW'(0));
		send_request(FN_POW, 3, 0, EW'(PRIME - 2));
		send_request(FN_INV, 0, 0, 0);
		send_request(FN_INV, 1, 0, 0);
		send_request(FN_INV, DW'(PRIME - 1), 0, 0);
		send_request(FN_INV, ~DW'(0), 0, 0);
		send_request(3'd6, 9, 9, 9);
		send_request(3'd7, ~DW'(0), ~DW'(0), ~EW'(0));
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		hold_output = 1;
		for (int i = 0; i < 4; i++) begin
			send_request(FN_MUL, rand_residue(), rand_residue(), 0);
		end
		hold_output = 0;
		wait_drained();
	endtask

	task automatic test_random(int n);
		logic [FW-1:0] f;
		for (int i = 0; i < n; i++) begin
			f = ($urandom_range(0, 24) == 0) ? FW'($urandom_range(6, 7))
				: FW'($urandom_range(0, 5));
			send_request(f, rand_residue(), rand_residue(), rand_exponent());
			if (i == n / 2) begin
				wait_drained();
			end
		end
		wait_drained();
	endtask

	task automatic test_no_idle(int n);
		long_stalls = 0;
		for (int i = 0; i < n; i++) begin
			send_request(FW'($urandom_range(0, 5)), rand_residue(), rand_residue(),
				rand_exponent());
		end
		long_stalls = 1;
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			result_count <= result_count + 1;
			if (expected_residues.size() == 0) begin
				$error("result %0d arrived with no item outstanding", result);
				error_count <= error_count + 1;
			end else begin
				if (result !== expected_residues[0]) begin
					$error("result: expected %0d, actual %0d", expected_residues[0], result);
					error_count <= error_count + 1;
				end
				void'(expected_residues.pop_front());
			end
		end
	end

	initial begin
		int hold;
		out_ready = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_output) begin
				out_ready <= 0;
				for (hold = 0; hold < 300; hold++) @(posedge clk);
				out_ready <= 1;
				wait (!hold_output);
			end else if (long_stalls && $urandom_range(0, 99) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		func = 0;
		operand_a = 0;
		operand_b = 0;
		exponent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_output_backpressure();
		test_random(1100);
		test_no_idle(200);
		repeat (50) @(posedge clk);
		$display("Covered %0d items, %0d results: add %0d sub %0d mul %0d div %0d",
			item_count, result_count, op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("pow %0d inv %0d unused %0d, with random idling and a long output hold.",
			op_count[4], op_count[5], op_count[6] + op_count[7]);
		if (error_count == 0 && expected_residues.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pma_pkg.sv
hw/rtl/pma_mulmod.sv
hw/rtl/pma_divstep.sv
hw/rtl/prime_modular_arith_unit.sv
tb/sv/prime_modular_arith_unit_tb.sv
